>>> hdl/spfm_pkg.sv
package spfm_pkg;

    localparam int MAG_FIELD_W      = 16;
    localparam int PAN_W            = 16;
    localparam int MAG_BITS         = 16;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int GUARD_BITS       = 28;
    localparam int MAG_USE_W        = (MAG_BITS < MAG_FIELD_W) ? MAG_BITS : MAG_FIELD_W;
    localparam int XY_W             = MAG_USE_W + GUARD_BITS + 3;
    localparam int ANGLE_W          = 32;
    localparam int Z_W              = ANGLE_W + 2;
    localparam int ATAN_DEPTH       = 24;

    typedef logic [ANGLE_W-1:0] angle_t;

    // Angles are fractions of pi with 2^32 standing for pi.
    localparam angle_t ANGLE_HALF_PI = 32'h8000_0000;
    // Three quarters plus half an output LSB, for round half up.
    localparam angle_t PAN_BIAS      = 32'hC000_8000;

    // atan(2^-i)/pi in the angle format above.
    localparam angle_t ATAN_TABLE [ATAN_DEPTH] = '{
        32'd1073741824, 32'd633866811, 32'd334917815, 32'd170009512,
        32'd85334662,   32'd42708931,  32'd21359677,  32'd10680490,
        32'd5340327,    32'd2670173,   32'd1335088,   32'd667544,
        32'd333772,     32'd166886,    32'd83443,     32'd41722,
        32'd20861,      32'd10430,     32'd5215,      32'd2608,
        32'd1304,       32'd652,       32'd326,       32'd163
    };

    typedef struct packed {
        logic                   special;
        logic                   left_zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } stage_t;

endpackage

>>> hdl/stereo_pan_from_magnitudes.sv
// A word accepted on the input passes through one input stage, one stage per CORDIC rotation,
// a scaling stage and an output register before it appears on m_valid.
// Throughput: one word per cycle; the pipeline only halts while the skid register is full.
// Reset (aresetn low at a clock edge) empties every stage; no result survives it.
module stereo_pan_from_magnitudes
    import spfm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [MAG_FIELD_W-1:0] s_left_magnitude,
    input  logic [MAG_FIELD_W-1:0] s_right_magnitude,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PAN_W-1:0]       m_pan_position
);

    localparam int N = ANGLE_ITERATIONS;
    localparam logic [PAN_W-1:0] PAN_MIN = PAN_W'(16'h4000);
    localparam logic [PAN_W-1:0] PAN_MAX = PAN_W'(16'hC000);

    logic                 pipe_ce;
    logic                 out_free;
    logic [N:0]           vld_reg;
    logic [N:0]           vld_next;
    stage_t               stg_reg  [0:N];
    stage_t               stg_next [0:N];
    logic [MAG_USE_W-1:0] l_mag;
    logic [MAG_USE_W-1:0] r_mag;
    stage_t               entry_stage;

    logic                 p_valid_reg;
    logic [PAN_W-1:0]     p_pan_reg;
    logic [PAN_W-1:0]     p_pan_next;
    angle_t               z_sat;
    angle_t               pan_full;

    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic [PAN_W-1:0]     skid_pan_reg;
    logic [PAN_W-1:0]     skid_pan_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [PAN_W-1:0]     m_pan_reg;
    logic [PAN_W-1:0]     m_pan_next;

    assign pipe_ce = !skid_valid_reg;
    assign s_ready = pipe_ce;

    assign l_mag = s_left_magnitude[MAG_USE_W-1:0];
    assign r_mag = s_right_magnitude[MAG_USE_W-1:0];

    // A zero magnitude gives an exact angle, so the rotations are bypassed.
    always_comb begin
        entry_stage.special   = (r_mag == '0) || (l_mag == '0);
        entry_stage.left_zero = (r_mag != '0) && (l_mag == '0);
        entry_stage.x = $signed({{(XY_W-MAG_USE_W){1'b0}}, l_mag}) <<< GUARD_BITS;
        entry_stage.y = $signed({{(XY_W-MAG_USE_W){1'b0}}, r_mag}) <<< GUARD_BITS;
        entry_stage.z = '0;
    end

    assign stg_next[0] = entry_stage;
    assign vld_next    = {vld_reg[N-1:0], s_valid};

    for (genvar i = 0; i < N; i++) begin : g_rot
        logic signed [Z_W-1:0] step_angle;
        stage_t                rot;

        assign step_angle = $signed({{(Z_W-ANGLE_W){1'b0}}, ATAN_TABLE[i]});

        always_comb begin
            rot = stg_reg[i];
            if (!stg_reg[i].y[XY_W-1]) begin
                rot.x = stg_reg[i].x + (stg_reg[i].y >>> i);
                rot.y = stg_reg[i].y - (stg_reg[i].x >>> i);
                rot.z = stg_reg[i].z + step_angle;
            end else begin
                rot.x = stg_reg[i].x - (stg_reg[i].y >>> i);
                rot.y = stg_reg[i].y + (stg_reg[i].x >>> i);
                rot.z = stg_reg[i].z - step_angle;
            end
        end

        assign stg_next[i+1] = rot;
    end

    // Clamp the angle to zero..pi/2 and map it to the pan fraction.
    always_comb begin
        if (stg_reg[N].special) begin
            z_sat = stg_reg[N].left_zero ? ANGLE_HALF_PI : '0;
        end else if (stg_reg[N].z[Z_W-1]) begin
            z_sat = '0;
        end else if (stg_reg[N].z > $signed({{(Z_W-ANGLE_W){1'b0}}, ANGLE_HALF_PI})) begin
            z_sat = ANGLE_HALF_PI;
        end else begin
            z_sat = stg_reg[N].z[ANGLE_W-1:0];
        end
        pan_full   = PAN_BIAS - z_sat;
        p_pan_next = pan_full[ANGLE_W-1 -: PAN_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            p_valid_reg <= 1'b0;
        end else if (pipe_ce) begin
            vld_reg     <= vld_next;
            p_valid_reg <= vld_reg[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            for (int k = 0; k <= N; k++) begin
                stg_reg[k] <= stg_next[k];
            end
            p_pan_reg <= p_pan_next;
        end
    end

    // The skid register catches the word leaving the pipeline while the output is stalled.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_pan_next      = m_pan_reg;
        skid_valid_next = skid_valid_reg;
        skid_pan_next   = skid_pan_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_pan_next      = skid_pan_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = p_valid_reg;
                m_pan_next   = p_pan_reg;
            end
        end else if (pipe_ce && p_valid_reg) begin
            skid_valid_next = 1'b1;
            skid_pan_next   = p_pan_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        m_pan_reg    <= m_pan_next;
        skid_pan_reg <= skid_pan_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_pan_position = m_pan_reg;

    a_skid_behind_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register holds a word while the output register is empty");

    a_skid_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_ready) |=> (skid_valid_reg && $stable(skid_pan_reg)))
        else $error("skid word lost or changed during an output stall");

    a_pan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_pan_position >= PAN_MIN) && (m_pan_position <= PAN_MAX)))
        else $error("pan position outside one quarter to three quarters");

endmodule
